@@ hdl/mttp_pkg.sv @@
// Shared constants and types of the trapezoid profile planner.
`default_nettype none
package mttp_pkg;

  localparam int MTTP_FRAC_BITS = 16;
  localparam int MTTP_WORD_BITS = 32;
  localparam int MTTP_CFG_IDX_W = 2;

  localparam logic [MTTP_CFG_IDX_W-1:0] CFG_MIN_VEL = 2'd0;
  localparam logic [MTTP_CFG_IDX_W-1:0] CFG_MAX_VEL = 2'd1;
  localparam logic [MTTP_CFG_IDX_W-1:0] CFG_ACCEL   = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_VEL = 2'd1;
  localparam logic [1:0] ST_NON_POS = 2'd2;
  localparam logic [1:0] ST_SHORT   = 2'd3;

  localparam logic [2:0] MV_ZERO    = 3'd0;
  localparam logic [2:0] MV_ACCEL   = 3'd1;
  localparam logic [2:0] MV_DECEL   = 3'd2;
  localparam logic [2:0] MV_ACC_DEC = 3'd3;
  localparam logic [2:0] MV_SAT     = 3'd4;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] move_type;
    logic [2:0] point_count;
    logic       need_root;
    logic       br3;
    logic       br4;
  } mttp_ctl_t;

endpackage
`default_nettype wire

@@ hdl/min_time_trapezoid_profile_unit.sv @@
// Top level of the minimum-time trapezoid profile planner.
// Takes one move request per cycle while the chain is not stalled; words are Q16.16 by
// default. A request passes operand check, products and classification, WORD_BITS cells
// of the square root chain, a ramp setup register, 2*WORD_BITS + FRAC_BITS cells of the
// three parallel divider chains (two ramp times and the cruise time), a register for
// summing and saturation and a write into the output queue.
// Results leave through a two-entry queue; the whole chain stalls only while that
// queue is full and the sink holds off. Configuration writes are taken every cycle.
`default_nettype none
module min_time_trapezoid_profile_unit #(
  parameter int FRAC_BITS = mttp_pkg::MTTP_FRAC_BITS,
  parameter int WORD_BITS = mttp_pkg::MTTP_WORD_BITS
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  // distance, start_velocity, final_velocity, zero pad
  input  logic [((3*WORD_BITS+7)/8)*8-1:0]             in_tdata,
  input  logic                                         in_tvalid,
  output logic                                         in_tready,
  // status, move_type, point_count, time_1..time_3, velocity_0..velocity_3, zero pad
  output logic [((7*WORD_BITS+11)/8)*8-1:0]            out_tdata,
  output logic                                         out_tvalid,
  input  logic                                         out_tready,
  input  logic                                         cfg_valid,
  output logic                                         cfg_ready,
  input  logic [mttp_pkg::MTTP_CFG_IDX_W-1:0]          cfg_index,
  input  logic [WORD_BITS-1:0]                         cfg_data
);
  import mttp_pkg::*;

  localparam int W     = WORD_BITS;
  localparam int F     = FRAC_BITS;
  localparam int PW    = 2 * W;
  localparam int NQ    = PW + F;
  localparam int SQ_N  = W;
  localparam int RW    = W + 2;
  localparam int RES_W = 7 * W + 4;
  localparam int OUT_W = ((7 * W + 11) / 8) * 8;

  typedef struct packed {
    mttp_ctl_t     ctl;
    logic [W-2:0]  v0;
    logic [W-2:0]  v1;
    logic [W-2:0]  vf;
    logic [W-2:0]  acc;
    logic [PW-1:0] numc;
    logic [PW-1:0] denc;
  } sq_sb_t;

  typedef struct packed {
    mttp_ctl_t    ctl;
    logic [W-2:0] v0;
    logic [W-2:0] peak;
    logic [W-2:0] vf;
  } dv_sb_t;

  // configuration
  logic [W-1:0] min_vel_r, max_vel_r, acc_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_vel_r <= '0;
      max_vel_r <= {{(W-1){1'b0}}, 1'b1} << F;
      acc_r     <= {{(W-1){1'b0}}, 1'b1} << F;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MIN_VEL: min_vel_r <= cfg_data;
        CFG_MAX_VEL: max_vel_r <= cfg_data;
        CFG_ACCEL:   acc_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // flow control
  logic       en, fin_vld_r, push, pop;
  logic [1:0] q_cnt_r;

  assign en        = !(q_cnt_r == 2'd2 && !out_tready) || !fin_vld_r;
  assign in_tready = en;

  // front end
  logic          f_vld;
  mttp_ctl_t     f_ctl;
  logic [W-2:0]  f_v0, f_v1, f_vf, f_acc;
  logic [PW-1:0] f_rad, f_numc, f_denc;

  mttp_front #(.WORD_BITS(W)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (en),
    .vld_i          (in_tvalid),
    .distance       (in_tdata[W-1:0]),
    .start_velocity (in_tdata[2*W-1:W]),
    .final_velocity (in_tdata[3*W-1:2*W]),
    .min_velocity   (min_vel_r),
    .max_velocity   (max_vel_r),
    .acceleration   (acc_r),
    .vld_o          (f_vld),
    .ctl_o          (f_ctl),
    .v0_o           (f_v0),
    .v1_o           (f_v1),
    .vf_o           (f_vf),
    .acc_o          (f_acc),
    .rad_o          (f_rad),
    .numc_o         (f_numc),
    .denc_o         (f_denc)
  );

  // square root chain
  logic [PW-1:0] sx    [SQ_N+1];
  logic [RW-1:0] srem  [SQ_N+1];
  logic [W-1:0]  sroot [SQ_N+1];
  logic          sq_vld_w [SQ_N+1];
  logic          sq_vld_r [SQ_N];
  sq_sb_t        sq_sb_w  [SQ_N+1];
  sq_sb_t        sq_sb_r  [SQ_N];

  assign sx[0]       = f_rad;
  assign srem[0]     = '0;
  assign sroot[0]    = '0;
  assign sq_vld_w[0] = f_vld;
  assign sq_sb_w[0]  = '{ctl: f_ctl, v0: f_v0, v1: f_v1, vf: f_vf, acc: f_acc,
                         numc: f_numc, denc: f_denc};

  for (genvar i = 0; i < SQ_N; i++) begin : g_sqrt
    mttp_sqrt_cell #(.WORD_BITS(W)) u_cell (
      .clk    (clk),
      .en     (en),
      .x_i    (sx[i]),
      .rem_i  (srem[i]),
      .root_i (sroot[i]),
      .x_o    (sx[i+1]),
      .rem_o  (srem[i+1]),
      .root_o (sroot[i+1])
    );

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[i] <= 1'b0;
      end else if (en) begin
        sq_vld_r[i] <= sq_vld_w[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_sb_r[i] <= sq_sb_w[i];
      end
    end

    assign sq_vld_w[i+1] = sq_vld_r[i];
    assign sq_sb_w[i+1]  = sq_sb_r[i];
  end

  // ramp setup
  sq_sb_t        sq_end;
  logic [W-2:0]  peak_c, dva_c, dvb_c;
  logic          pr_vld_r;
  dv_sb_t        pr_sb_r;
  logic [NQ-1:0] pr_numa_r, pr_numb_r, pr_numc_r;
  logic [W-2:0]  pr_acc_r;
  logic [PW-1:0] pr_denc_r;

  assign sq_end = sq_sb_w[SQ_N];

  always_comb begin
    peak_c = sq_end.ctl.need_root ? sroot[SQ_N][W-2:0] : sq_end.v1;
    dva_c  = peak_c - sq_end.v0;
    dvb_c  = peak_c - sq_end.vf;
    if (!sq_end.ctl.br3 && !sq_end.ctl.br4) begin
      dvb_c = '0;
      dva_c = (sq_end.v0 > peak_c) ? (sq_end.v0 - peak_c) : (peak_c - sq_end.v0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pr_vld_r <= 1'b0;
    end else if (en) begin
      pr_vld_r <= sq_vld_w[SQ_N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pr_sb_r   <= '{ctl: sq_end.ctl, v0: sq_end.v0, peak: peak_c, vf: sq_end.vf};
      pr_numa_r <= NQ'({dva_c, {F{1'b0}}});
      pr_numb_r <= NQ'({dvb_c, {F{1'b0}}});
      pr_numc_r <= {sq_end.numc, {F{1'b0}}};
      pr_acc_r  <= sq_end.acc;
      pr_denc_r <= sq_end.denc;
    end
  end

  // divider chains
  logic [NQ-1:0] da_num [NQ+1], db_num [NQ+1], dc_num [NQ+1];
  logic [NQ-1:0] da_quo [NQ+1], db_quo [NQ+1], dc_quo [NQ+1];
  logic [W-2:0]  da_den [NQ+1], db_den [NQ+1], da_rem [NQ+1], db_rem [NQ+1];
  logic [PW-1:0] dc_den [NQ+1], dc_rem [NQ+1];
  logic          dv_vld_w [NQ+1];
  logic          dv_vld_r [NQ];
  dv_sb_t        dv_sb_w  [NQ+1];
  dv_sb_t        dv_sb_r  [NQ];

  assign da_num[0]   = pr_numa_r;
  assign db_num[0]   = pr_numb_r;
  assign dc_num[0]   = pr_numc_r;
  assign da_den[0]   = pr_acc_r;
  assign db_den[0]   = pr_acc_r;
  assign dc_den[0]   = pr_denc_r;
  assign da_rem[0]   = '0;
  assign db_rem[0]   = '0;
  assign dc_rem[0]   = '0;
  assign da_quo[0]   = '0;
  assign db_quo[0]   = '0;
  assign dc_quo[0]   = '0;
  assign dv_vld_w[0] = pr_vld_r;
  assign dv_sb_w[0]  = pr_sb_r;

  for (genvar i = 0; i < NQ; i++) begin : g_div
    mttp_div_cell #(.NUM_W(NQ), .DEN_W(W-1)) u_cell_a (
      .clk   (clk),
      .en    (en),
      .num_i (da_num[i]),
      .den_i (da_den[i]),
      .rem_i (da_rem[i]),
      .quo_i (da_quo[i]),
      .num_o (da_num[i+1]),
      .den_o (da_den[i+1]),
      .rem_o (da_rem[i+1]),
      .quo_o (da_quo[i+1])
    );

    mttp_div_cell #(.NUM_W(NQ), .DEN_W(W-1)) u_cell_b (
      .clk   (clk),
      .en    (en),
      .num_i (db_num[i]),
      .den_i (db_den[i]),
      .rem_i (db_rem[i]),
      .quo_i (db_quo[i]),
      .num_o (db_num[i+1]),
      .den_o (db_den[i+1]),
      .rem_o (db_rem[i+1]),
      .quo_o (db_quo[i+1])
    );

    mttp_div_cell #(.NUM_W(NQ), .DEN_W(PW)) u_cell_c (
      .clk   (clk),
      .en    (en),
      .num_i (dc_num[i]),
      .den_i (dc_den[i]),
      .rem_i (dc_rem[i]),
      .quo_i (dc_quo[i]),
      .num_o (dc_num[i+1]),
      .den_o (dc_den[i+1]),
      .rem_o (dc_rem[i+1]),
      .quo_o (dc_quo[i+1])
    );

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[i] <= 1'b0;
      end else if (en) begin
        dv_vld_r[i] <= dv_vld_w[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_sb_r[i] <= dv_sb_w[i];
      end
    end

    assign dv_vld_w[i+1] = dv_vld_r[i];
    assign dv_sb_w[i+1]  = dv_sb_r[i];
  end

  // sum, saturate and pack
  function automatic logic [W-1:0] sat_w(input logic [NQ+1:0] x);
    sat_w = (|x[NQ+1:W]) ? '1 : x[W-1:0];
  endfunction

  dv_sb_t         dv_end;
  logic [NQ+1:0]  qa_c, qb_c, qc_c, s2_c, s3_c;
  logic [W-1:0]   t1_c, t2_c, t3_c;
  logic [W-2:0]   v0_c, v1_c, v2_c, v3_c;
  logic [2:0]     mv_c, cnt_c;
  logic [RES_W-1:0] fin_res_r;

  assign dv_end = dv_sb_w[NQ];
  assign qa_c   = (NQ+2)'(da_quo[NQ]);
  assign qb_c   = (NQ+2)'(db_quo[NQ]);
  assign qc_c   = (NQ+2)'(dc_quo[NQ]);
  assign s3_c   = qa_c + qb_c + qc_c;
  assign s2_c   = qa_c + qc_c + (dv_end.ctl.br3 ? qb_c : '0);

  always_comb begin
    mv_c  = dv_end.ctl.move_type;
    cnt_c = dv_end.ctl.point_count;
    t1_c  = sat_w(qa_c);
    t2_c  = (dv_end.ctl.br3 || dv_end.ctl.br4) ? sat_w(s2_c) : '0;
    t3_c  = dv_end.ctl.br4 ? sat_w(s3_c) : '0;
    v0_c  = dv_end.v0;
    v1_c  = dv_end.peak;
    v2_c  = dv_end.ctl.br3 ? dv_end.vf : (dv_end.ctl.br4 ? dv_end.peak : '0);
    v3_c  = dv_end.ctl.br4 ? dv_end.vf : '0;
    if (dv_end.ctl.status != ST_OK) begin
      mv_c  = '0;
      cnt_c = '0;
      t1_c  = '0;
      t2_c  = '0;
      t3_c  = '0;
      v0_c  = '0;
      v1_c  = '0;
      v2_c  = '0;
      v3_c  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_vld_r <= 1'b0;
    end else if (en) begin
      fin_vld_r <= dv_vld_w[NQ];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_res_r <= {v3_c, v2_c, v1_c, v0_c, t3_c, t2_c, t1_c, cnt_c, mv_c,
                    dv_end.ctl.status};
    end
  end

  // output queue
  logic [RES_W-1:0] q_mem_r [2];
  logic             q_wr_r, q_rd_r;
  logic [RES_W-1:0] out_res;

  assign push       = en && fin_vld_r;
  assign pop        = out_tvalid && out_tready;
  assign out_tvalid = (q_cnt_r != 2'd0);
  assign out_res    = q_mem_r[q_rd_r];
  assign out_tdata  = OUT_W'(out_res);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= 2'd0;
      q_wr_r  <= 1'b0;
      q_rd_r  <= 1'b0;
    end else begin
      if (push) begin
        q_wr_r <= ~q_wr_r;
      end
      if (pop) begin
        q_rd_r <= ~q_rd_r;
      end
      case ({push, pop})
        2'b10:   q_cnt_r <= q_cnt_r + 2'd1;
        2'b01:   q_cnt_r <= q_cnt_r - 2'd1;
        default: q_cnt_r <= q_cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[q_wr_r] <= fin_res_r;
    end
  end

  a_queue_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (q_cnt_r == $past(q_cnt_r) + 2'd1))
    else $error("queue count did not advance on push");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_res[1:0] != ST_OK) |-> (out_res[RES_W-1:2] == '0))
    else $error("error result carries nonzero fields");

  a_ok_points: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_res[1:0] == ST_OK) |->
      (out_res[7:5] == 3'd2 || out_res[7:5] == 3'd3 || out_res[7:5] == 3'd4))
    else $error("valid result with bad point count");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_vld_r && q_cnt_r == 2'd2 && !out_tready) |=> $stable(fin_res_r))
    else $error("final stage advanced while queue full");

endmodule
`default_nettype wire

@@ hdl/mttp_front.sv @@
// Operand check, wide products and move classification (two stages).
`default_nettype none
module mttp_front #(
  parameter int WORD_BITS = mttp_pkg::MTTP_WORD_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          vld_i,
  input  logic signed [WORD_BITS-1:0]   distance,
  input  logic signed [WORD_BITS-1:0]   start_velocity,
  input  logic signed [WORD_BITS-1:0]   final_velocity,
  input  logic signed [WORD_BITS-1:0]   min_velocity,
  input  logic signed [WORD_BITS-1:0]   max_velocity,
  input  logic signed [WORD_BITS-1:0]   acceleration,
  output logic                          vld_o,
  output mttp_pkg::mttp_ctl_t           ctl_o,
  output logic [WORD_BITS-2:0]          v0_o,
  output logic [WORD_BITS-2:0]          v1_o,
  output logic [WORD_BITS-2:0]          vf_o,
  output logic [WORD_BITS-2:0]          acc_o,
  output logic [2*WORD_BITS-1:0]        rad_o,
  output logic [2*WORD_BITS-1:0]        numc_o,
  output logic [2*WORD_BITS-1:0]        denc_o
);
  import mttp_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int PW = 2 * W;

  logic          bad_vel, non_pos;
  logic [W-1:0]  acc2, dist_u;
  logic [PW-1:0] lhs_c, sq0_c, sqf_c, sqm_c, den_c;
  logic [1:0]    st_c;

  logic          vld1_r;
  logic [1:0]    st1_r;
  logic [PW-1:0] lhs_r, sq0_r, sqf_r, sqm_r, den_r;
  logic [W-2:0]  v0_r, vf_r, vm_r, a_r;

  assign bad_vel = (min_velocity < 0) || (max_velocity <= min_velocity) ||
                   (start_velocity < min_velocity) || (start_velocity > max_velocity) ||
                   (final_velocity < min_velocity) || (final_velocity > max_velocity);
  assign non_pos = (distance <= 0) || (acceleration <= 0);
  assign st_c    = bad_vel ? ST_BAD_VEL : (non_pos ? ST_NON_POS : ST_OK);

  assign acc2   = {acceleration[W-2:0], 1'b0};
  assign dist_u = distance;
  assign lhs_c  = {{W{1'b0}}, acc2} * {{W{1'b0}}, dist_u};
  assign sq0_c  = {{(W+1){1'b0}}, start_velocity[W-2:0]} *
                  {{(W+1){1'b0}}, start_velocity[W-2:0]};
  assign sqf_c  = {{(W+1){1'b0}}, final_velocity[W-2:0]} *
                  {{(W+1){1'b0}}, final_velocity[W-2:0]};
  assign sqm_c  = {{(W+1){1'b0}}, max_velocity[W-2:0]} *
                  {{(W+1){1'b0}}, max_velocity[W-2:0]};
  assign den_c  = {{W{1'b0}}, acc2} * {{(W+1){1'b0}}, max_velocity[W-2:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else if (en) begin
      vld1_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st1_r <= st_c;
      lhs_r <= lhs_c;
      sq0_r <= sq0_c;
      sqf_r <= sqf_c;
      sqm_r <= sqm_c;
      den_r <= den_c;
      v0_r  <= start_velocity[W-2:0];
      vf_r  <= final_velocity[W-2:0];
      vm_r  <= max_velocity[W-2:0];
      a_r   <= acceleration[W-2:0];
    end
  end

  logic [PW-1:0] bar_c, s_c, sum_c, numc_c, denc_c;
  logic [W-2:0]  v1_c;
  mttp_ctl_t     ctl_c;

  logic          vld2_r;
  mttp_ctl_t     ctl2_r;
  logic [W-2:0]  v02_r, v12_r, vf2_r, a2_r;
  logic [PW-1:0] rad2_r, numc2_r, denc2_r;

  assign bar_c = (sq0_r >= sqf_r) ? (sq0_r - sqf_r) : (sqf_r - sq0_r);
  assign s_c   = (sqm_r << 1) - sq0_r - sqf_r;
  assign sum_c = lhs_r + sq0_r + sqf_r;

  always_comb begin
    ctl_c  = '0;
    numc_c = '0;
    denc_c = {{(PW-1){1'b0}}, 1'b1};
    v1_c   = vf_r;
    if (st1_r != ST_OK) begin
      ctl_c.status = st1_r;
    end else if (lhs_r < bar_c) begin
      ctl_c.status = ST_SHORT;
    end else if (lhs_r == bar_c) begin
      ctl_c.move_type   = (v0_r < vf_r) ? MV_ACCEL : ((v0_r == vf_r) ? MV_ZERO : MV_DECEL);
      ctl_c.point_count = 3'd2;
    end else if (lhs_r > s_c) begin
      ctl_c.move_type   = MV_SAT;
      ctl_c.point_count = 3'd4;
      ctl_c.br4         = 1'b1;
      v1_c              = vm_r;
      numc_c            = lhs_r - s_c;
      denc_c            = den_r;
    end else begin
      ctl_c.move_type   = MV_ACC_DEC;
      ctl_c.point_count = 3'd3;
      ctl_c.br3         = 1'b1;
      ctl_c.need_root   = (lhs_r != s_c);
      v1_c              = vm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else if (en) begin
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl2_r  <= ctl_c;
      v02_r   <= v0_r;
      v12_r   <= v1_c;
      vf2_r   <= vf_r;
      a2_r    <= a_r;
      rad2_r  <= sum_c >> 1;
      numc2_r <= numc_c;
      denc2_r <= denc_c;
    end
  end

  assign vld_o  = vld2_r;
  assign ctl_o  = ctl2_r;
  assign v0_o   = v02_r;
  assign v1_o   = v12_r;
  assign vf_o   = vf2_r;
  assign acc_o  = a2_r;
  assign rad_o  = rad2_r;
  assign numc_o = numc2_r;
  assign denc_o = denc2_r;

endmodule
`default_nettype wire

@@ hdl/mttp_sqrt_cell.sv @@
// One step of the restoring square root chain: two radicand bits, one root bit.
`default_nettype none
module mttp_sqrt_cell #(
  parameter int WORD_BITS = mttp_pkg::MTTP_WORD_BITS
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [2*WORD_BITS-1:0] x_i,
  input  logic [WORD_BITS+1:0]   rem_i,
  input  logic [WORD_BITS-1:0]   root_i,
  output logic [2*WORD_BITS-1:0] x_o,
  output logic [WORD_BITS+1:0]   rem_o,
  output logic [WORD_BITS-1:0]   root_o
);
  localparam int W  = WORD_BITS;
  localparam int XW = 2 * W;
  localparam int RW = W + 2;

  logic [RW+1:0] cat_c, trial_c, diff_c;
  logic          ge_c;

  logic [XW-1:0] x_r;
  logic [RW-1:0] rem_r;
  logic [W-1:0]  root_r;

  assign cat_c   = {rem_i, x_i[XW-1:XW-2]};
  assign trial_c = {2'b00, root_i, 2'b01};
  assign ge_c    = (cat_c >= trial_c);
  assign diff_c  = cat_c - trial_c;

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= {x_i[XW-3:0], 2'b00};
      rem_r  <= ge_c ? diff_c[RW-1:0] : cat_c[RW-1:0];
      root_r <= {root_i[W-2:0], ge_c};
    end
  end

  assign x_o    = x_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;

endmodule
`default_nettype wire

@@ hdl/mttp_div_cell.sv @@
// One step of the restoring divider chain: one quotient bit.
`default_nettype none
module mttp_div_cell #(
  parameter int NUM_W = 80,
  parameter int DEN_W = 64
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [DEN_W-1:0] rem_i,
  input  logic [NUM_W-1:0] quo_i,
  output logic [NUM_W-1:0] num_o,
  output logic [DEN_W-1:0] den_o,
  output logic [DEN_W-1:0] rem_o,
  output logic [NUM_W-1:0] quo_o
);
  logic [DEN_W:0]   cat_c, diff_c;
  logic             ge_c;

  logic [NUM_W-1:0] num_r, quo_r;
  logic [DEN_W-1:0] den_r, rem_r;

  assign cat_c  = {rem_i, num_i[NUM_W-1]};
  assign ge_c   = (cat_c >= {1'b0, den_i});
  assign diff_c = cat_c - {1'b0, den_i};

  always_ff @(posedge clk) begin
    if (en) begin
      num_r <= {num_i[NUM_W-2:0], 1'b0};
      den_r <= den_i;
      rem_r <= ge_c ? diff_c[DEN_W-1:0] : cat_c[DEN_W-1:0];
      quo_r <= {quo_i[NUM_W-2:0], ge_c};
    end
  end

  assign num_o = num_r;
  assign den_o = den_r;
  assign rem_o = rem_r;
  assign quo_o = quo_r;

endmodule
`default_nettype wire
